[rtl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared widths, stage counts, branch codes and beat structures for the
// segment-to-segment distance pipeline.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int COORD_WIDTH = 11;
  localparam int FRAC_BITS   = 20;

  localparam int DW    = COORD_WIDTH + 1;
  localparam int PW    = 2 * DW;
  localparam int DOTW  = PW + 2;
  localparam int MW    = 2 * DOTW;
  localparam int XW    = MW + 1;
  localparam int EW    = DOTW + 1;
  localparam int DENW  = 4 * COORD_WIDTH + 4;
  localparam int PRW   = DENW + DW + 1;
  localparam int COMPW = PRW + 2;
  localparam int MAGW  = COMPW - 1;
  localparam int LOW   = MAGW / 2;
  localparam int HIW   = MAGW - LOW;
  localparam int SQW   = 2 * MAGW;
  localparam int NW    = SQW + 2;
  localparam int DHALF = DENW / 2;
  localparam int DHI   = DENW - DHALF;
  localparam int DNW   = 2 * DENW;
  localparam int OW    = 32;
  localparam int QW    = 2 * OW;
  localparam int SH    = QW - 2 * FRAC_BITS;

  localparam int PARAM_STAGES = 7;
  localparam int NORM_STAGES  = 7;
  localparam int LATENCY      = PARAM_STAGES + NORM_STAGES + QW + OW + 1;

  localparam int SELW = 3;
  localparam logic [SELW-1:0] SEL_INNER = 3'd0;
  localparam logic [SELW-1:0] SEL_CL0   = 3'd1;
  localparam logic [SELW-1:0] SEL_CL1   = 3'd2;
  localparam logic [SELW-1:0] SEL_FT0   = 3'd3;
  localparam logic [SELW-1:0] SEL_FT1   = 3'd4;

  typedef struct packed {
    logic [2:0][DW-1:0] d1;
    logic [2:0][DW-1:0] d2;
    logic [2:0][DW-1:0] v0;
  } dir_t;

  typedef struct packed {
    logic            vld;
    logic [DENW-1:0] sn;
    logic [DENW-1:0] tn;
    logic [DENW-1:0] den;
    dir_t            dir;
  } geo_t;

  typedef struct packed {
    logic           vld;
    logic           sat;
    logic [DNW-1:0] rem;
    logic [DNW-1:0] dn;
    logic [QW-1:0]  nlow;
  } divin_t;

  typedef struct packed {
    logic          vld;
    logic          sat;
    logic [QW-1:0] q;
  } sqin_t;

  typedef struct packed {
    logic          vld;
    logic          sat;
    logic [OW-1:0] root;
  } root_t;

endpackage

[rtl/ssd_param.sv]
// ----------------------------------------------------------------------------
// ssd_param
// Forms the direction vectors, the dot products and the determinant, picks
// the clamping branch and produces the line parameters over one denominator.
// ----------------------------------------------------------------------------
module ssd_param (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic [2:0][ssd_pkg::COORD_WIDTH-1:0]   a0,
  input  logic [2:0][ssd_pkg::COORD_WIDTH-1:0]   a1,
  input  logic [2:0][ssd_pkg::COORD_WIDTH-1:0]   b0,
  input  logic [2:0][ssd_pkg::COORD_WIDTH-1:0]   b1,
  output ssd_pkg::geo_t                          geo
);

  logic [ssd_pkg::PARAM_STAGES-1:0] vld_r;
  ssd_pkg::dir_t dir_r [ssd_pkg::PARAM_STAGES];
  ssd_pkg::dir_t dir_nxt;

  logic signed [ssd_pkg::PW-1:0] paa_r [3];
  logic signed [ssd_pkg::PW-1:0] pbb_r [3];
  logic signed [ssd_pkg::PW-1:0] pcc_r [3];
  logic signed [ssd_pkg::PW-1:0] pdd_r [3];
  logic signed [ssd_pkg::PW-1:0] pee_r [3];

  logic signed [ssd_pkg::DOTW-1:0] a3_r, b3_r, c3_r, d3_r, e3_r;
  logic signed [ssd_pkg::DOTW-1:0] a4_r, b4_r, c4_r, d4_r, e4_r;
  logic signed [ssd_pkg::MW-1:0]   ac4_r, bb4_r, be4_r, cd4_r, ae4_r, bd4_r;

  logic signed [ssd_pkg::XW-1:0]   det5_r, s05_r, t05_r;
  logic signed [ssd_pkg::DOTW-1:0] a5_r, c5_r, e5_r;
  logic signed [ssd_pkg::EW-1:0]   bpe5_r, bmd5_r, nd5_r;

  logic [ssd_pkg::SELW-1:0]        sel_nxt, sel6_r;
  logic signed [ssd_pkg::XW-1:0]   det6_r, s06_r, t06_r;
  logic signed [ssd_pkg::DOTW-1:0] a6_r, c6_r, e6_r;
  logic signed [ssd_pkg::EW-1:0]   bpe6_r, bmd6_r, nd6_r;

  logic [ssd_pkg::DENW-1:0] sn_nxt, tn_nxt, den_nxt;
  logic [ssd_pkg::DENW-1:0] sn7_r, tn7_r, den7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ssd_pkg::PARAM_STAGES-2:0], start};
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dir_nxt.d1[k] = {a0[k][ssd_pkg::COORD_WIDTH-1], a0[k]}
                    - {a1[k][ssd_pkg::COORD_WIDTH-1], a1[k]};
      dir_nxt.d2[k] = {b0[k][ssd_pkg::COORD_WIDTH-1], b0[k]}
                    - {b1[k][ssd_pkg::COORD_WIDTH-1], b1[k]};
      dir_nxt.v0[k] = {a1[k][ssd_pkg::COORD_WIDTH-1], a1[k]}
                    - {b1[k][ssd_pkg::COORD_WIDTH-1], b1[k]};
    end
  end

  always_ff @(posedge clk) begin
    dir_r[0] <= dir_nxt;
    for (int i = 1; i < ssd_pkg::PARAM_STAGES; i++) begin
      dir_r[i] <= dir_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      paa_r[k] <= $signed(dir_r[0].d1[k]) * $signed(dir_r[0].d1[k]);
      pbb_r[k] <= $signed(dir_r[0].d1[k]) * $signed(dir_r[0].d2[k]);
      pcc_r[k] <= $signed(dir_r[0].d2[k]) * $signed(dir_r[0].d2[k]);
      pdd_r[k] <= $signed(dir_r[0].d1[k]) * $signed(dir_r[0].v0[k]);
      pee_r[k] <= $signed(dir_r[0].d2[k]) * $signed(dir_r[0].v0[k]);
    end
  end

  always_ff @(posedge clk) begin
    a3_r <= ssd_pkg::DOTW'(paa_r[0]) + ssd_pkg::DOTW'(paa_r[1]) + ssd_pkg::DOTW'(paa_r[2]);
    b3_r <= ssd_pkg::DOTW'(pbb_r[0]) + ssd_pkg::DOTW'(pbb_r[1]) + ssd_pkg::DOTW'(pbb_r[2]);
    c3_r <= ssd_pkg::DOTW'(pcc_r[0]) + ssd_pkg::DOTW'(pcc_r[1]) + ssd_pkg::DOTW'(pcc_r[2]);
    d3_r <= ssd_pkg::DOTW'(pdd_r[0]) + ssd_pkg::DOTW'(pdd_r[1]) + ssd_pkg::DOTW'(pdd_r[2]);
    e3_r <= ssd_pkg::DOTW'(pee_r[0]) + ssd_pkg::DOTW'(pee_r[1]) + ssd_pkg::DOTW'(pee_r[2]);
  end

  always_ff @(posedge clk) begin
    ac4_r <= a3_r * c3_r;
    bb4_r <= b3_r * b3_r;
    be4_r <= b3_r * e3_r;
    cd4_r <= c3_r * d3_r;
    ae4_r <= a3_r * e3_r;
    bd4_r <= b3_r * d3_r;
    a4_r  <= a3_r;
    b4_r  <= b3_r;
    c4_r  <= c3_r;
    d4_r  <= d3_r;
    e4_r  <= e3_r;
  end

  always_ff @(posedge clk) begin
    det5_r <= ssd_pkg::XW'(ac4_r) - ssd_pkg::XW'(bb4_r);
    s05_r  <= ssd_pkg::XW'(be4_r) - ssd_pkg::XW'(cd4_r);
    t05_r  <= ssd_pkg::XW'(ae4_r) - ssd_pkg::XW'(bd4_r);
    bpe5_r <= ssd_pkg::EW'(b4_r) + ssd_pkg::EW'(e4_r);
    bmd5_r <= ssd_pkg::EW'(b4_r) - ssd_pkg::EW'(d4_r);
    nd5_r  <= -ssd_pkg::EW'(d4_r);
    a5_r   <= a4_r;
    c5_r   <= c4_r;
    e5_r   <= e4_r;
  end

  always_comb begin
    logic s_in;
    logic t_in;
    s_in = (s05_r >= 0) && (s05_r <= det5_r);
    t_in = (t05_r >= 0) && (t05_r <= det5_r);
    if (det5_r > 0) begin
      if (s_in && t_in) begin
        sel_nxt = ssd_pkg::SEL_INNER;
      end else if (s05_r <= 0) begin
        if (e5_r <= 0) begin
          sel_nxt = ssd_pkg::SEL_CL0;
        end else if (e5_r < c5_r) begin
          sel_nxt = ssd_pkg::SEL_FT0;
        end else begin
          sel_nxt = ssd_pkg::SEL_CL1;
        end
      end else if (s05_r >= det5_r) begin
        if (bpe5_r <= 0) begin
          sel_nxt = ssd_pkg::SEL_CL0;
        end else if (bpe5_r < ssd_pkg::EW'(c5_r)) begin
          sel_nxt = ssd_pkg::SEL_FT1;
        end else begin
          sel_nxt = ssd_pkg::SEL_CL1;
        end
      end else begin
        if (t05_r <= 0) begin
          sel_nxt = ssd_pkg::SEL_CL0;
        end else if (t05_r >= det5_r) begin
          sel_nxt = ssd_pkg::SEL_CL1;
        end else begin
          sel_nxt = ssd_pkg::SEL_INNER;
        end
      end
    end else begin
      if ((c5_r > 0) && (e5_r >= 0) && (e5_r <= c5_r)) begin
        sel_nxt = ssd_pkg::SEL_FT0;
      end else if (e5_r <= 0) begin
        sel_nxt = ssd_pkg::SEL_CL0;
      end else if (e5_r >= c5_r) begin
        sel_nxt = ssd_pkg::SEL_CL1;
      end else begin
        sel_nxt = ssd_pkg::SEL_FT0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sel6_r <= sel_nxt;
    det6_r <= det5_r;
    s06_r  <= s05_r;
    t06_r  <= t05_r;
    a6_r   <= a5_r;
    c6_r   <= c5_r;
    e6_r   <= e5_r;
    bpe6_r <= bpe5_r;
    bmd6_r <= bmd5_r;
    nd6_r  <= nd5_r;
  end

  always_comb begin
    logic signed [ssd_pkg::EW-1:0] x;
    logic                          tfix;
    tfix = (sel6_r == ssd_pkg::SEL_CL1);
    x    = tfix ? bmd6_r : nd6_r;
    case (sel6_r)
      ssd_pkg::SEL_INNER: begin
        sn_nxt  = ssd_pkg::DENW'(s06_r);
        tn_nxt  = ssd_pkg::DENW'(t06_r);
        den_nxt = ssd_pkg::DENW'(det6_r);
      end
      ssd_pkg::SEL_FT0: begin
        sn_nxt  = '0;
        tn_nxt  = ssd_pkg::DENW'(e6_r);
        den_nxt = ssd_pkg::DENW'(c6_r);
      end
      ssd_pkg::SEL_FT1: begin
        sn_nxt  = ssd_pkg::DENW'(c6_r);
        tn_nxt  = ssd_pkg::DENW'(bpe6_r);
        den_nxt = ssd_pkg::DENW'(c6_r);
      end
      ssd_pkg::SEL_CL0, ssd_pkg::SEL_CL1: begin
        if (x <= 0) begin
          sn_nxt  = '0;
          tn_nxt  = ssd_pkg::DENW'(tfix);
          den_nxt = ssd_pkg::DENW'(1);
        end else if (x >= ssd_pkg::EW'(a6_r)) begin
          sn_nxt  = ssd_pkg::DENW'(1);
          tn_nxt  = ssd_pkg::DENW'(tfix);
          den_nxt = ssd_pkg::DENW'(1);
        end else begin
          sn_nxt  = ssd_pkg::DENW'(x);
          tn_nxt  = tfix ? ssd_pkg::DENW'(a6_r) : '0;
          den_nxt = ssd_pkg::DENW'(a6_r);
        end
      end
      default: begin
        sn_nxt  = '0;
        tn_nxt  = '0;
        den_nxt = ssd_pkg::DENW'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sn7_r  <= sn_nxt;
    tn7_r  <= tn_nxt;
    den7_r <= den_nxt;
  end

  always_comb begin
    geo.vld = vld_r[ssd_pkg::PARAM_STAGES-1];
    geo.sn  = sn7_r;
    geo.tn  = tn7_r;
    geo.den = den7_r;
    geo.dir = dir_r[ssd_pkg::PARAM_STAGES-1];
  end

endmodule

[rtl/ssd_norm.sv]
// ----------------------------------------------------------------------------
// ssd_norm
// Builds the squared length of the closest-point vector scaled by the
// denominator squared, the denominator squared, and the divider's start beat.
// ----------------------------------------------------------------------------
module ssd_norm (
  input  logic             clk,
  input  logic             rst_n,
  input  ssd_pkg::geo_t    geo,
  output ssd_pkg::divin_t  dv
);

  logic [ssd_pkg::NORM_STAGES-1:0] vld_r;

  logic signed [ssd_pkg::PRW-1:0] pv_r [3];
  logic signed [ssd_pkg::PRW-1:0] ps_r [3];
  logic signed [ssd_pkg::PRW-1:0] pt_r [3];
  logic [2*ssd_pkg::DHI-1:0]            dhh8_r;
  logic [ssd_pkg::DHI+ssd_pkg::DHALF-1:0] dhl8_r;
  logic [2*ssd_pkg::DHALF-1:0]          dll8_r;

  logic signed [ssd_pkg::COMPW-1:0] comp9_r [3];
  logic [ssd_pkg::MAGW-1:0]         mag10_r [3];
  logic [2*ssd_pkg::HIW-1:0]            hh11_r [3];
  logic [ssd_pkg::HIW+ssd_pkg::LOW-1:0] hl11_r [3];
  logic [2*ssd_pkg::LOW-1:0]            ll11_r [3];
  logic [ssd_pkg::SQW-1:0]          sq12_r [3];
  logic [ssd_pkg::NW-1:0]           n13_r;
  logic [ssd_pkg::DNW-1:0]          dn9_r, dn10_r, dn11_r, dn12_r, dn13_r;

  logic [ssd_pkg::NW-1:0] top_c;
  logic                   sat14_r;
  logic [ssd_pkg::DNW-1:0] rem14_r;
  logic [ssd_pkg::DNW-1:0] dn14_r;
  logic [ssd_pkg::QW-1:0]  nlow14_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ssd_pkg::NORM_STAGES-2:0], geo.vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pv_r[k] <= $signed({1'b0, geo.den}) * $signed(geo.dir.v0[k]);
      ps_r[k] <= $signed({1'b0, geo.sn}) * $signed(geo.dir.d1[k]);
      pt_r[k] <= $signed({1'b0, geo.tn}) * $signed(geo.dir.d2[k]);
    end
    dhh8_r <= geo.den[ssd_pkg::DENW-1:ssd_pkg::DHALF] * geo.den[ssd_pkg::DENW-1:ssd_pkg::DHALF];
    dhl8_r <= geo.den[ssd_pkg::DENW-1:ssd_pkg::DHALF] * geo.den[ssd_pkg::DHALF-1:0];
    dll8_r <= geo.den[ssd_pkg::DHALF-1:0] * geo.den[ssd_pkg::DHALF-1:0];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      comp9_r[k] <= ssd_pkg::COMPW'(pv_r[k]) + ssd_pkg::COMPW'(ps_r[k])
                  - ssd_pkg::COMPW'(pt_r[k]);
    end
    dn9_r <= (ssd_pkg::DNW'(dhh8_r) << (2 * ssd_pkg::DHALF))
           + (ssd_pkg::DNW'(dhl8_r) << (ssd_pkg::DHALF + 1))
           + ssd_pkg::DNW'(dll8_r);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag10_r[k] <= comp9_r[k][ssd_pkg::COMPW-1] ? ssd_pkg::MAGW'(-comp9_r[k])
                                                 : ssd_pkg::MAGW'(comp9_r[k]);
    end
    dn10_r <= dn9_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      hh11_r[k] <= mag10_r[k][ssd_pkg::MAGW-1:ssd_pkg::LOW]
                 * mag10_r[k][ssd_pkg::MAGW-1:ssd_pkg::LOW];
      hl11_r[k] <= mag10_r[k][ssd_pkg::MAGW-1:ssd_pkg::LOW]
                 * mag10_r[k][ssd_pkg::LOW-1:0];
      ll11_r[k] <= mag10_r[k][ssd_pkg::LOW-1:0] * mag10_r[k][ssd_pkg::LOW-1:0];
    end
    dn11_r <= dn10_r;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      sq12_r[k] <= (ssd_pkg::SQW'(hh11_r[k]) << (2 * ssd_pkg::LOW))
                 + (ssd_pkg::SQW'(hl11_r[k]) << (ssd_pkg::LOW + 1))
                 + ssd_pkg::SQW'(ll11_r[k]);
    end
    dn12_r <= dn11_r;
  end

  always_ff @(posedge clk) begin
    n13_r  <= ssd_pkg::NW'(sq12_r[0]) + ssd_pkg::NW'(sq12_r[1]) + ssd_pkg::NW'(sq12_r[2]);
    dn13_r <= dn12_r;
  end

  assign top_c = n13_r >> ssd_pkg::SH;

  always_ff @(posedge clk) begin
    sat14_r  <= top_c >= ssd_pkg::NW'(dn13_r);
    rem14_r  <= top_c[ssd_pkg::DNW-1:0];
    dn14_r   <= dn13_r;
    nlow14_r <= n13_r[ssd_pkg::QW-1:0] << (2 * ssd_pkg::FRAC_BITS);
  end

  always_comb begin
    dv.vld  = vld_r[ssd_pkg::NORM_STAGES-1];
    dv.sat  = sat14_r;
    dv.rem  = rem14_r;
    dv.dn   = dn14_r;
    dv.nlow = nlow14_r;
  end

endmodule

[rtl/ssd_div.sv]
// ----------------------------------------------------------------------------
// ssd_div
// Restoring divider, one quotient bit per stage, giving the squared distance
// in fixed point as the scaled norm over the squared denominator.
// ----------------------------------------------------------------------------
module ssd_div (
  input  logic             clk,
  input  logic             rst_n,
  input  ssd_pkg::divin_t  dv,
  output ssd_pkg::sqin_t   sq
);

  logic                     vld_r  [ssd_pkg::QW];
  logic                     sat_r  [ssd_pkg::QW];
  logic [ssd_pkg::QW-1:0]   q_r    [ssd_pkg::QW];
  logic [ssd_pkg::DNW-1:0]  rem_r  [ssd_pkg::QW-1];
  logic [ssd_pkg::DNW-1:0]  dn_r   [ssd_pkg::QW-1];
  logic [ssd_pkg::QW-1:0]   nlow_r [ssd_pkg::QW-1];

  logic                     src_vld  [ssd_pkg::QW];
  logic                     src_sat  [ssd_pkg::QW];
  logic [ssd_pkg::QW-1:0]   src_q    [ssd_pkg::QW];
  logic [ssd_pkg::DNW-1:0]  src_rem  [ssd_pkg::QW];
  logic [ssd_pkg::DNW-1:0]  src_dn   [ssd_pkg::QW];
  logic [ssd_pkg::QW-1:0]   src_nlow [ssd_pkg::QW];

  assign src_vld[0]  = dv.vld;
  assign src_sat[0]  = dv.sat;
  assign src_q[0]    = '0;
  assign src_rem[0]  = dv.rem;
  assign src_dn[0]   = dv.dn;
  assign src_nlow[0] = dv.nlow;

  for (genvar k = 0; k < ssd_pkg::QW; k++) begin : g_step
    logic [ssd_pkg::DNW:0] rem2;
    logic                  ge;

    if (k > 0) begin : g_src
      assign src_vld[k]  = vld_r[k-1];
      assign src_sat[k]  = sat_r[k-1];
      assign src_q[k]    = q_r[k-1];
      assign src_rem[k]  = rem_r[k-1];
      assign src_dn[k]   = dn_r[k-1];
      assign src_nlow[k] = nlow_r[k-1];
    end

    assign rem2 = {src_rem[k], src_nlow[k][ssd_pkg::QW-1]};
    assign ge   = rem2 >= {1'b0, src_dn[k]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      sat_r[k] <= src_sat[k];
      q_r[k]   <= {src_q[k][ssd_pkg::QW-2:0], ge};
    end

    if (k < ssd_pkg::QW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        rem_r[k]  <= ge ? ssd_pkg::DNW'(rem2 - {1'b0, src_dn[k]}) : rem2[ssd_pkg::DNW-1:0];
        dn_r[k]   <= src_dn[k];
        nlow_r[k] <= src_nlow[k] << 1;
      end
    end
  end

  always_comb begin
    sq.vld = vld_r[ssd_pkg::QW-1];
    sq.sat = sat_r[ssd_pkg::QW-1];
    sq.q   = q_r[ssd_pkg::QW-1];
  end

endmodule

[rtl/ssd_sqrt.sv]
// ----------------------------------------------------------------------------
// ssd_sqrt
// Digit-by-digit integer square root, one root bit per stage, truncating
// toward zero.
// ----------------------------------------------------------------------------
module ssd_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  ssd_pkg::sqin_t  sq,
  output ssd_pkg::root_t  rt
);

  logic                    vld_r  [ssd_pkg::OW];
  logic                    sat_r  [ssd_pkg::OW];
  logic [ssd_pkg::OW-1:0]  root_r [ssd_pkg::OW];
  logic [ssd_pkg::OW-1:0]  rem_r  [ssd_pkg::OW-1];
  logic [ssd_pkg::QW-1:0]  x_r    [ssd_pkg::OW-1];

  logic                    src_vld  [ssd_pkg::OW];
  logic                    src_sat  [ssd_pkg::OW];
  logic [ssd_pkg::OW-1:0]  src_root [ssd_pkg::OW];
  logic [ssd_pkg::OW-1:0]  src_rem  [ssd_pkg::OW];
  logic [ssd_pkg::QW-1:0]  src_x    [ssd_pkg::OW];

  assign src_vld[0]  = sq.vld;
  assign src_sat[0]  = sq.sat;
  assign src_root[0] = '0;
  assign src_rem[0]  = '0;
  assign src_x[0]    = sq.q;

  for (genvar k = 0; k < ssd_pkg::OW; k++) begin : g_step
    logic [ssd_pkg::OW+1:0] rem2;
    logic [ssd_pkg::OW+1:0] trial;
    logic                   ge;

    if (k > 0) begin : g_src
      assign src_vld[k]  = vld_r[k-1];
      assign src_sat[k]  = sat_r[k-1];
      assign src_root[k] = root_r[k-1];
      assign src_rem[k]  = rem_r[k-1];
      assign src_x[k]    = x_r[k-1];
    end

    assign rem2  = {src_rem[k], src_x[k][ssd_pkg::QW-1:ssd_pkg::QW-2]};
    assign trial = {src_root[k], 2'b01};
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= src_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      sat_r[k]  <= src_sat[k];
      root_r[k] <= {src_root[k][ssd_pkg::OW-2:0], ge};
    end

    if (k < ssd_pkg::OW - 1) begin : g_keep
      always_ff @(posedge clk) begin
        rem_r[k] <= ge ? ssd_pkg::OW'(rem2 - trial) : ssd_pkg::OW'(rem2);
        x_r[k]   <= src_x[k] << 2;
      end
    end
  end

  always_comb begin
    rt.vld  = vld_r[ssd_pkg::OW-1];
    rt.sat  = sat_r[ssd_pkg::OW-1];
    rt.root = root_r[ssd_pkg::OW-1];
  end

endmodule

[rtl/segment_segment_distance_3d_core.sv]
// ----------------------------------------------------------------------------
// segment_segment_distance_3d_core
// Shortest Euclidean distance between two 3D segments, unsigned Q12.20.
// ----------------------------------------------------------------------------
// A beat is offered by raising start with the twelve endpoint coordinates on
// the in_ ports; it is taken at a rising edge where start is high and busy is
// low. Busy is low whenever the block is out of reset, so a new beat may be
// taken on every clock edge.
// Each beat gives one result beat: out_valid is high for exactly one cycle
// with out_distance. Beats leave in the order they arrived, one per cycle at
// most.
// The stage chain is seven stages of dot products and branch selection,
// seven stages of norm and denominator products, a 64-stage restoring
// divider and a 32-stage square root, plus the output register.
// The receiver cannot hold results off, and the block never needs it to.
// Synchronous reset drops every valid bit in the pipeline; beats in flight
// are discarded and busy stays high while reset is held.
// ----------------------------------------------------------------------------
module segment_segment_distance_3d_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [ssd_pkg::COORD_WIDTH-1:0] in_a0_x,
  input  logic signed [ssd_pkg::COORD_WIDTH-1:0] in_a0_y,
  input  logic signed [ssd_pkg::COORD_WIDTH-1:0] in_a0_z,
  input  logic signed [ssd_pkg::COORD_WIDTH-1:0] in_a1_x,
  input  logic signed [ssd_pkg::COORD_WIDTH-1:0] in_a1_y,
  input  logic signed [ssd_pkg::COORD_WIDTH-1:0] in_a1_z,
  input  logic signed [ssd_pkg::COORD_WIDTH-1:0] in_b0_x,
  input  logic signed [ssd_pkg::COORD_WIDTH-1:0] in_b0_y,
  input  logic signed [ssd_pkg::COORD_WIDTH-1:0] in_b0_z,
  input  logic signed [ssd_pkg::COORD_WIDTH-1:0] in_b1_x,
  input  logic signed [ssd_pkg::COORD_WIDTH-1:0] in_b1_y,
  input  logic signed [ssd_pkg::COORD_WIDTH-1:0] in_b1_z,
  output logic                                   out_valid,
  output logic [ssd_pkg::OW-1:0]                 out_distance
);

  logic [2:0][ssd_pkg::COORD_WIDTH-1:0] a0_w, a1_w, b0_w, b1_w;
  ssd_pkg::geo_t   geo;
  ssd_pkg::divin_t dv;
  ssd_pkg::sqin_t  sq;
  ssd_pkg::root_t  rt;
  logic                   out_valid_r;
  logic [ssd_pkg::OW-1:0] out_distance_r;

  assign busy = ~rst_n;

  assign a0_w = {in_a0_z, in_a0_y, in_a0_x};
  assign a1_w = {in_a1_z, in_a1_y, in_a1_x};
  assign b0_w = {in_b0_z, in_b0_y, in_b0_x};
  assign b1_w = {in_b1_z, in_b1_y, in_b1_x};

  ssd_param u_param (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .a0    (a0_w),
    .a1    (a1_w),
    .b0    (b0_w),
    .b1    (b1_w),
    .geo   (geo)
  );

  ssd_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .geo   (geo),
    .dv    (dv)
  );

  ssd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .dv    (dv),
    .sq    (sq)
  );

  ssd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .sq    (sq),
    .rt    (rt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rt.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_distance_r <= rt.sat ? '1 : rt.root;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(ssd_pkg::LATENCY) out_valid)
    else $error("accepted beat did not produce a result on time");

  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, ssd_pkg::LATENCY))
    else $error("result beat without a matching accepted beat");

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

[bench/tb_segment_segment_distance_3d_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_segment_distance_3d_core
// Drives segment pairs into the distance pipeline and checks every distance
// beat against an exact wide-integer prediction of floor(dist * 2^20).
// Directed pairs cover the coordinate extremes, parallel and point segments
// and every clamping branch; random traffic follows with varying start gaps.
// ----------------------------------------------------------------------------
module tb_segment_segment_distance_3d_core;

  typedef logic signed [ssd_pkg::COORD_WIDTH-1:0] coord_t;
  typedef struct {
    coord_t a0 [3];
    coord_t a1 [3];
    coord_t b0 [3];
    coord_t b1 [3];
  } seg_pair_t;

  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  coord_t in_a0_x = '0, in_a0_y = '0, in_a0_z = '0;
  coord_t in_a1_x = '0, in_a1_y = '0, in_a1_z = '0;
  coord_t in_b0_x = '0, in_b0_y = '0, in_b0_z = '0;
  coord_t in_b1_x = '0, in_b1_y = '0, in_b1_z = '0;
  logic out_valid;
  logic [ssd_pkg::OW-1:0] out_distance;

  logic [ssd_pkg::OW-1:0] pending_distance [$];
  int failures = 0;
  int quiet_cycles = 0;
  int start_gap_pct = 0;

  always #10 clk = ~clk;

  segment_segment_distance_3d_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a0_x(in_a0_x), .in_a0_y(in_a0_y), .in_a0_z(in_a0_z),
    .in_a1_x(in_a1_x), .in_a1_y(in_a1_y), .in_a1_z(in_a1_z),
    .in_b0_x(in_b0_x), .in_b0_y(in_b0_y), .in_b0_z(in_b0_z),
    .in_b1_x(in_b1_x), .in_b1_y(in_b1_y), .in_b1_z(in_b1_z),
    .out_valid(out_valid), .out_distance(out_distance)
  );

  function automatic void clamp_s(input longint x, input longint a, input longint tfix,
                                  output longint sn, output longint tn, output longint den);
    if (x <= 0) begin
      sn = 0; tn = tfix; den = 1;
    end else if (x >= a) begin
      sn = 1; tn = tfix; den = 1;
    end else begin
      sn = x; tn = tfix * a; den = a;
    end
  endfunction

  function automatic logic [ssd_pkg::OW-1:0] seg_distance_q(seg_pair_t p);
    longint d1 [3], d2 [3], v0 [3];
    longint a, b, c, d, e, det, s0, t0, sn, tn, den;
    logic signed [255:0] n, comp, dn, m, cw, wden;
    logic [ssd_pkg::OW-1:0] r, cand;
    for (int k = 0; k < 3; k++) begin
      d1[k] = longint'(p.a0[k]) - longint'(p.a1[k]);
      d2[k] = longint'(p.b0[k]) - longint'(p.b1[k]);
      v0[k] = longint'(p.a1[k]) - longint'(p.b1[k]);
    end
    a = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
    b = d1[0]*d2[0] + d1[1]*d2[1] + d1[2]*d2[2];
    c = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
    d = d1[0]*v0[0] + d1[1]*v0[1] + d1[2]*v0[2];
    e = d2[0]*v0[0] + d2[1]*v0[1] + d2[2]*v0[2];
    det = a * c - b * b;
    if (det > 0) begin
      s0 = b * e - c * d;
      t0 = a * e - b * d;
      if (s0 >= 0 && s0 <= det && t0 >= 0 && t0 <= det) begin
        sn = s0; tn = t0; den = det;
      end else if (s0 <= 0) begin
        if (e <= 0) clamp_s(-d, a, 0, sn, tn, den);
        else if (e < c) begin
          sn = 0; tn = e; den = c;
        end else clamp_s(b - d, a, 1, sn, tn, den);
      end else if (s0 >= det) begin
        if (b + e <= 0) clamp_s(-d, a, 0, sn, tn, den);
        else if (b + e < c) begin
          sn = c; tn = b + e; den = c;
        end else clamp_s(b - d, a, 1, sn, tn, den);
      end else begin
        if (t0 <= 0) clamp_s(-d, a, 0, sn, tn, den);
        else if (t0 >= det) clamp_s(b - d, a, 1, sn, tn, den);
        else begin
          sn = s0; tn = t0; den = det;
        end
      end
    end else begin
      if ((c > 0 && e >= 0 && e <= c) || !(e <= 0 || e >= c)) begin
        sn = 0; tn = e; den = c;
      end else if (e <= 0) clamp_s(-d, a, 0, sn, tn, den);
      else clamp_s(b - d, a, 1, sn, tn, den);
    end
    n = '0;
    wden = den;
    for (int k = 0; k < 3; k++) begin
      comp = wden * v0[k] + 256'(signed'(sn)) * d1[k] - 256'(signed'(tn)) * d2[k];
      n = n + comp * comp;
    end
    dn = wden * wden;
    m = n <<< (2 * ssd_pkg::FRAC_BITS);
    r = '0;
    for (int bit_i = ssd_pkg::OW - 1; bit_i >= 0; bit_i--) begin
      cand = r | (32'd1 << bit_i);
      cw = {224'd0, cand};
      if (cw * cw * dn <= m) r = cand;
    end
    return r;
  endfunction

  function automatic seg_pair_t build_seg_pair(int ax0, int ay0, int az0, int ax1, int ay1,
                                               int az1, int bx0, int by0, int bz0, int bx1,
                                               int by1, int bz1);
    seg_pair_t p;
    p.a0 = '{coord_t'(ax0), coord_t'(ay0), coord_t'(az0)};
    p.a1 = '{coord_t'(ax1), coord_t'(ay1), coord_t'(az1)};
    p.b0 = '{coord_t'(bx0), coord_t'(by0), coord_t'(bz0)};
    p.b1 = '{coord_t'(bx1), coord_t'(by1), coord_t'(bz1)};
    return p;
  endfunction

  task automatic send_pair(seg_pair_t p);
    while ($urandom_range(99) < start_gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_a0_x <= p.a0[0]; in_a0_y <= p.a0[1]; in_a0_z <= p.a0[2];
    in_a1_x <= p.a1[0]; in_a1_y <= p.a1[1]; in_a1_z <= p.a1[2];
    in_b0_x <= p.b0[0]; in_b0_y <= p.b0[1]; in_b0_z <= p.b0[2];
    in_b1_x <= p.b1[0]; in_b1_y <= p.b1[1]; in_b1_z <= p.b1[2];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_distance.push_back(seg_distance_q(p));
  endtask

  task automatic test_extremes();
    send_pair(build_seg_pair(-1024, -1024, -1024, 1023, 1023, 1023,
                             1023, 1023, 1023, -1024, -1024, -1024));
    send_pair(build_seg_pair(-1024, -1024, -1024, -1024, -1024, -1024,
                             1023, 1023, 1023, 1023, 1023, 1023));
    send_pair(build_seg_pair(-1024, 1023, -1024, 1023, -1024, 1023,
                             1023, -1024, -1024, -1024, 1023, 1023));
    send_pair(build_seg_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(build_seg_pair(-1, -1, -1, 1023, 0, 0, -1024, 1023, -1, 0, -1024, 1023));
  endtask

  task automatic test_parallel();
    send_pair(build_seg_pair(0, 0, 0, 10, 0, 0, 0, 5, 0, 10, 5, 0));
    send_pair(build_seg_pair(0, 0, 0, 10, 0, 0, 20, 3, 0, 30, 3, 0));
    send_pair(build_seg_pair(0, 0, 0, 10, 0, 0, -30, 3, 0, -20, 3, 0));
    send_pair(build_seg_pair(0, 0, 0, 10, 0, 0, 30, 3, 4, -20, 3, 4));
    send_pair(build_seg_pair(-1024, -1024, 0, 1023, 1023, 0, 1023, 1023, 7, -1024, -1024, 7));
  endtask

  task automatic test_point_segments();
    send_pair(build_seg_pair(3, 4, 0, 3, 4, 0, 0, 0, 0, 0, 0, 0));
    send_pair(build_seg_pair(5, 5, 5, 5, 5, 5, 0, 0, 0, 10, 0, 0));
    send_pair(build_seg_pair(0, 0, 0, 10, 0, 0, 5, 7, 1, 5, 7, 1));
    send_pair(build_seg_pair(1023, -1024, 1023, 1023, -1024, 1023, -1024, 1023, -1024,
                             -1024, 1023, -1024));
  endtask

  task automatic test_clamping();
    send_pair(build_seg_pair(-5, 0, 0, 5, 0, 0, 0, -5, 3, 0, 5, 3));
    send_pair(build_seg_pair(0, 0, 0, 10, 0, 0, -5, -5, 2, -5, 5, 2));
    send_pair(build_seg_pair(0, 0, 0, 10, 0, 0, 15, -5, 2, 15, 5, 2));
    send_pair(build_seg_pair(0, 0, 0, 10, 0, 0, 3, 4, 2, 3, 14, 2));
    send_pair(build_seg_pair(0, 0, 0, 10, 0, 0, 3, -14, 2, 3, -4, 2));
    send_pair(build_seg_pair(0, 0, 0, 10, 0, 0, 12, 8, 1, 25, 20, 9));
    send_pair(build_seg_pair(0, 0, 0, 10, 0, 0, -12, 8, 1, -25, 20, 9));
  endtask

  function automatic int rand_span(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic test_random_traffic(int count, int gap_pct);
    seg_pair_t p;
    int kind, lim, scale;
    start_gap_pct = gap_pct;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      lim = (kind < 3) ? 1024 : ($urandom_range(1) ? 20 : 300);
      for (int k = 0; k < 3; k++) begin
        if (kind < 2) begin
          p.a0[k] = coord_t'($urandom); p.a1[k] = coord_t'($urandom);
          p.b0[k] = coord_t'($urandom); p.b1[k] = coord_t'($urandom);
        end else begin
          p.a0[k] = coord_t'(rand_span(lim > 1023 ? 1023 : lim));
          p.a1[k] = coord_t'(rand_span(lim > 1023 ? 1023 : lim));
          p.b0[k] = coord_t'(rand_span(lim > 1023 ? 1023 : lim));
          p.b1[k] = coord_t'(rand_span(lim > 1023 ? 1023 : lim));
        end
      end
      if (kind == 7 || kind == 8) begin
        scale = rand_span(3);
        for (int k = 0; k < 3; k++) begin
          p.a0[k] = coord_t'(rand_span(300));
          p.a1[k] = coord_t'(p.a0[k] + rand_span(60));
          p.b0[k] = coord_t'(rand_span(300));
          p.b1[k] = coord_t'(p.b0[k] + scale * (p.a1[k] - p.a0[k]));
        end
      end
      if (kind == 9) begin
        if ($urandom_range(1)) p.a1 = p.a0;
        else p.b1 = p.b0;
      end
      send_pair(p);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_distance.size() == 0) begin
        $error("distance beat with nothing expected: actual %0h", out_distance);
        failures++;
      end else begin
        if (out_distance !== pending_distance[0]) begin
          $error("distance mismatch: expected %0h actual %0h",
                 pending_distance[0], out_distance);
          failures++;
        end
        void'(pending_distance.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_parallel();
    test_point_segments();
    test_clamping();
    test_random_traffic(200, 32);
    test_random_traffic(200, 67);
    test_random_traffic(200, 0);
    start <= 1'b0;
    while (pending_distance.size() != 0) @(posedge clk);
    repeat (ssd_pkg::LATENCY + 10) @(posedge clk);
    if (failures == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

[sim.f]
rtl/ssd_pkg.sv
rtl/ssd_param.sv
rtl/ssd_norm.sv
rtl/ssd_div.sv
rtl/ssd_sqrt.sv
rtl/segment_segment_distance_3d_core.sv
bench/tb_segment_segment_distance_3d_core.sv
